### sv/abs_pkg.sv
// Shared types and constants for the alternating-bit sender.
// No dependencies; every module of the block imports this package.
package abs_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_MSG      = 2'd0,
    CMD_ACK_HDR  = 2'd1,
    CMD_ACK_BYTE = 2'd2,
    CMD_TIMEOUT  = 2'd3
  } cmd_e;

  // Result item kinds.
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STOP    = 2'd2
  } kind_e;

  // Work handed from the front end to the emitter.
  typedef enum logic [0:0] {
    JOB_SEND = 1'b0,
    JOB_STOP = 1'b1
  } job_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    logic               seq;
    logic signed [12:0] check;
  } job_t;

  localparam logic [15:0] RetransmitReset = 16'd15;

endpackage

### sv/abs_front.sv
// Front end of the alternating-bit sender: takes input items, keeps the
// protocol state and the payload store, and queues send and stop jobs.
// Depends on abs_pkg.
module abs_front #(
  parameter int PAYLOAD_BYTES = 20,
  localparam int IdxW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1,
  localparam int CntW = $clog2(PAYLOAD_BYTES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command_i,
  input  logic signed [7:0]  data_byte_i,
  input  logic               last_byte_i,
  input  logic signed [31:0] ack_seq_i,
  input  logic signed [31:0] ack_number_i,
  input  logic signed [31:0] ack_check_i,
  output logic               job_push_o,
  output abs_pkg::job_t      job_o,
  input  logic               job_full_i,
  input  logic               send_done_i,
  input  logic               rd_en_i,
  input  logic [IdxW-1:0]    rd_addr_i,
  output logic [7:0]         rd_data_o
);
  import abs_pkg::*;

  logic            wait_q, wait_d;
  logic            seq_q, seq_d;
  logic            disc_q, disc_d;
  logic            open_q, open_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] len_q, len_d;
  logic [12:0]     check_q, check_d;
  logic [31:0]     num_q, num_d;
  logic [31:0]     chk_q, chk_d;
  logic [31:0]     sum_q, sum_d;

  logic            accept;
  logic            first;
  logic            wr_en;
  logic [12:0]     check_n;
  logic [CntW-1:0] idx_n;
  logic [31:0]     sum_n;
  logic [31:0]     judge_chk;
  logic [31:0]     judge_num;

  logic [7:0]      mem [PAYLOAD_BYTES];
  logic [7:0]      rd_raw_q;
  logic            rd_zero_q;

  assign full   = open_q || job_full_i;
  assign accept = push && !full;
  assign first  = (idx_q == '0) && !disc_q;

  always_comb begin
    wait_d     = wait_q;
    seq_d      = seq_q;
    disc_d     = disc_q;
    idx_d      = idx_q;
    len_d      = len_q;
    check_d    = check_q;
    num_d      = num_q;
    chk_d      = chk_q;
    sum_d      = sum_q;
    wr_en      = 1'b0;
    check_n    = check_q;
    idx_n      = idx_q;
    sum_n      = sum_q;
    judge_chk  = chk_q;
    judge_num  = num_q;
    job_push_o = 1'b0;
    job_o      = '{kind: JOB_SEND, seq: seq_q, check: check_q};
    open_d     = open_q && !send_done_i;

    if (accept) begin
      unique case (cmd_e'(command_i))
        CMD_MSG: begin
          if (first && wait_q) begin
            // A message that opens while an ack is pending is dropped.
            if (!last_byte_i) begin
              disc_d = 1'b1;
            end
          end else if (disc_q) begin
            if (last_byte_i) begin
              disc_d = 1'b0;
            end
          end else begin
            check_n = first ? {12'd0, seq_q} : check_q;
            if (idx_q < CntW'(PAYLOAD_BYTES)) begin
              wr_en   = 1'b1;
              check_n = check_n + {{5{data_byte_i[7]}}, data_byte_i};
              idx_n   = idx_q + CntW'(1);
            end
            check_d = check_n;
            if (last_byte_i) begin
              len_d      = idx_n;
              idx_d      = '0;
              wait_d     = 1'b1;
              open_d     = 1'b1;
              job_push_o = 1'b1;
              job_o      = '{kind: JOB_SEND, seq: seq_q, check: check_n};
            end else begin
              idx_d = idx_n;
            end
          end
        end
        CMD_ACK_HDR: begin
          sum_n     = ack_seq_i + ack_number_i;
          num_d     = ack_number_i;
          chk_d     = ack_check_i;
          sum_d     = sum_n;
          judge_chk = ack_check_i;
          judge_num = ack_number_i;
        end
        CMD_ACK_BYTE: begin
          sum_n = sum_q + {{24{data_byte_i[7]}}, data_byte_i};
          sum_d = sum_n;
        end
        CMD_TIMEOUT: begin
          if (wait_q) begin
            open_d     = 1'b1;
            job_push_o = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // The ack is judged on its final item, header or payload byte.
      if ((command_i == CMD_ACK_HDR || command_i == CMD_ACK_BYTE) && last_byte_i &&
          wait_q && (judge_chk == sum_n) && (judge_num == {31'd0, seq_q})) begin
        job_push_o = 1'b1;
        job_o      = '{kind: JOB_STOP, seq: 1'b0, check: 13'd0};
        seq_d      = ~seq_q;
        wait_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q  <= 1'b0;
      seq_q   <= 1'b0;
      disc_q  <= 1'b0;
      open_q  <= 1'b0;
      idx_q   <= '0;
      len_q   <= '0;
      check_q <= '0;
      num_q   <= '0;
      chk_q   <= '0;
      sum_q   <= '0;
    end else begin
      wait_q  <= wait_d;
      seq_q   <= seq_d;
      disc_q  <= disc_d;
      open_q  <= open_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      check_q <= check_d;
      num_q   <= num_d;
      chk_q   <= chk_d;
      sum_q   <= sum_d;
    end
  end

  // Entries past the message length read as zero, so no fill pass is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q[IdxW-1:0]] <= data_byte_i;
    end
    if (rd_en_i) begin
      rd_raw_q  <= mem[rd_addr_i];
      rd_zero_q <= CntW'(rd_addr_i) >= len_q;
    end
  end

  assign rd_data_o = rd_zero_q ? 8'd0 : rd_raw_q;

endmodule

### sv/abs_jobq.sv
// Two-entry job queue between the front end and the emitter.
// Depends on abs_pkg for the job type.
module abs_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  abs_pkg::job_t wr_job_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          rd_en_i,
  output abs_pkg::job_t rd_job_o
);
  import abs_pkg::*;

  job_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_wr;
  logic       do_rd;

  assign full_o   = cnt_q[1];
  assign empty_o  = (cnt_q == 2'd0);
  assign rd_job_o = slot_q[rd_ptr_q];
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### sv/abs_back.sv
// Emitter of the alternating-bit sender: turns queued jobs into result
// items, replaying the payload store, and holds the output register.
// Depends on abs_pkg.
module abs_back #(
  parameter int PAYLOAD_BYTES = 20,
  localparam int IdxW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               job_empty_i,
  input  abs_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               send_done_o,
  output logic               rd_en_o,
  output logic [IdxW-1:0]    rd_addr_o,
  input  logic [7:0]         rd_data_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic               seq_number_o,
  output logic signed [12:0] check_value_o,
  output logic signed [7:0]  payload_byte_o,
  output logic               start_timer_o,
  output logic [15:0]        timer_load_o,
  output logic               last_o
);
  import abs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOAD = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            seq_q, seq_d;
  logic [15:0]     interval_q;
  logic            out_valid_q;

  logic            can_load;
  logic            load;
  logic            fin;
  kind_e           kind_d;
  logic            oseq_d;
  logic [12:0]     check_d;
  logic [7:0]      byte_d;
  logic            start_d;
  logic [15:0]     tload_d;
  logic            last_d;

  kind_e           kind_q;
  logic            oseq_q;
  logic [12:0]     check_q;
  logic [7:0]      byte_q;
  logic            start_q;
  logic [15:0]     tload_q;
  logic            last_q;

  assign can_load = !out_valid_q || pop;
  assign fin      = (idx_q == IdxW'(PAYLOAD_BYTES - 1));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    seq_d       = seq_q;
    load        = 1'b0;
    job_pop_o   = 1'b0;
    send_done_o = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = '0;
    kind_d      = KIND_STOP;
    oseq_d      = 1'b0;
    check_d     = '0;
    byte_d      = '0;
    start_d     = 1'b0;
    tload_d     = '0;
    last_d      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (!job_empty_i && can_load) begin
          job_pop_o = 1'b1;
          load      = 1'b1;
          if (job_i.kind == JOB_SEND) begin
            // Header goes out now while the first stored byte is fetched.
            kind_d    = KIND_HEADER;
            oseq_d    = job_i.seq;
            check_d   = job_i.check;
            last_d    = 1'b0;
            seq_d     = job_i.seq;
            idx_d     = '0;
            rd_en_o   = 1'b1;
            rd_addr_o = '0;
            state_d   = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (can_load) begin
          load    = 1'b1;
          kind_d  = KIND_PAYLOAD;
          oseq_d  = seq_q;
          byte_d  = rd_data_i;
          start_d = fin;
          tload_d = fin ? interval_q : 16'd0;
          last_d  = fin;
          if (fin) begin
            send_done_o = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            idx_d     = idx_q + IdxW'(1);
            rd_en_o   = 1'b1;
            rd_addr_o = idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      seq_q       <= 1'b0;
      interval_q  <= RetransmitReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      seq_q   <= seq_d;
      if (cfg_valid_i) begin
        interval_q <= cfg_data_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      oseq_q  <= oseq_d;
      check_q <= check_d;
      byte_q  <= byte_d;
      start_q <= start_d;
      tload_q <= tload_d;
      last_q  <= last_d;
    end
  end

  assign empty          = !out_valid_q;
  assign kind_o         = kind_q;
  assign seq_number_o   = oseq_q;
  assign check_value_o  = check_q;
  assign payload_byte_o = byte_q;
  assign start_timer_o  = start_q;
  assign timer_load_o   = tload_q;
  assign last_o         = last_q;

endmodule

### sv/alternating_bit_sender_unit.sv
// Alternating-bit sender, top level: front end, job queue and emitter.
// Depends on abs_pkg, abs_front, abs_jobq and abs_back.
//
// Input items enter through a queue-style port: an item transfers on a
// clock edge with push high and full low. Results leave the same way: the
// oldest result sits on the output ports while empty is low and transfers
// on an edge with pop high. The retransmit interval is written through the
// cfg channel, which is always ready.
// An item that causes no result is taken, and the next may follow at once.
// A message's last byte or a timer expiry while waiting starts a send of
// 1 + PAYLOAD_BYTES items: the header passes through the job queue into
// the output register, then one payload item per cycle while pop is held.
// full stays high from the input transfer until the final payload item
// has been loaded into the output register.
// An accepted ack produces one timer-stop item.
// If the receiver stops popping, the output register holds its item, the
// two-entry job queue fills and full rises. Reset clears all protocol state,
// sets the interval to 15 and empties the queue; no clearing pass is needed.
module alternating_bit_sender_unit #(
  parameter int PAYLOAD_BYTES = 20,
  localparam int IdxW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command_i,
  input  logic signed [7:0]  data_byte_i,
  input  logic               last_byte_i,
  input  logic signed [31:0] ack_seq_i,
  input  logic signed [31:0] ack_number_i,
  input  logic signed [31:0] ack_check_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic               seq_number_o,
  output logic signed [12:0] check_value_o,
  output logic signed [7:0]  payload_byte_o,
  output logic               start_timer_o,
  output logic [15:0]        timer_load_o,
  output logic               last_o
);
  import abs_pkg::*;

  logic            job_push;
  job_t            job_wr;
  logic            job_full;
  logic            job_empty;
  logic            job_pop;
  job_t            job_rd;
  logic            send_done;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]      rd_data;

  assign cfg_ready_o = 1'b1;

  abs_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .ack_seq_i   (ack_seq_i),
    .ack_number_i(ack_number_i),
    .ack_check_i (ack_check_i),
    .job_push_o  (job_push),
    .job_o       (job_wr),
    .job_full_i  (job_full),
    .send_done_i (send_done),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data)
  );

  abs_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (job_push),
    .wr_job_i(job_wr),
    .full_o  (job_full),
    .empty_o (job_empty),
    .rd_en_i (job_pop),
    .rd_job_o(job_rd)
  );

  abs_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .job_empty_i   (job_empty),
    .job_i         (job_rd),
    .job_pop_o     (job_pop),
    .send_done_o   (send_done),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .seq_number_o  (seq_number_o),
    .check_value_o (check_value_o),
    .payload_byte_o(payload_byte_o),
    .start_timer_o (start_timer_o),
    .timer_load_o  (timer_load_o),
    .last_o        (last_o)
  );

endmodule

### verif/alternating_bit_sender_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the alternating-bit sender. It watches the input, config and result
// transfers, predicts every result item and compares it with what the block sends.
// Depends on abs_pkg.
module alternating_bit_sender_checker #(
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [1:0]         command_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic [31:0]        ack_seq_i,
  input  logic [31:0]        ack_number_i,
  input  logic [31:0]        ack_check_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [1:0]         kind_i,
  input  logic               seq_number_i,
  input  logic signed [12:0] check_value_i,
  input  logic signed [7:0]  payload_byte_i,
  input  logic               start_timer_i,
  input  logic [15:0]        timer_load_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 owed_count_o,
  output logic               seq_bit_o
);
  import abs_pkg::*;

  typedef struct packed {
    kind_e              kind;
    logic               seq;
    logic signed [12:0] check;
    logic signed [7:0]  payload;
    logic               start;
    logic [15:0]        load;
    logic               last;
  } sender_item_t;

  sender_item_t owed_q[$];
  logic [15:0]  timer_interval;
  logic         awaiting_ack;
  logic         seq_bit;
  logic [7:0]   stored_bytes [PAYLOAD_BYTES];
  int           fill_count;
  logic [12:0]  msg_check;
  logic         dropping_msg;
  logic [31:0]  held_number;
  logic [31:0]  held_check;
  logic [31:0]  ack_sum;
  int           failures;

  function automatic sender_item_t make_item(kind_e k, logic s, logic [12:0] c,
                                             logic [7:0] p, logic st, logic [15:0] ld,
                                             logic l);
    sender_item_t item;
    item.kind    = k;
    item.seq     = s;
    item.check   = c;
    item.payload = p;
    item.start   = st;
    item.load    = ld;
    item.last    = l;
    return item;
  endfunction

  // A send or resend is one header followed by the whole payload store.
  function automatic void queue_packet();
    logic fin;
    int   i;
    owed_q.push_back(make_item(KIND_HEADER, seq_bit, msg_check, 8'd0, 1'b0, 16'd0, 1'b0));
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      fin = (i == PAYLOAD_BYTES - 1);
      owed_q.push_back(make_item(KIND_PAYLOAD, seq_bit, 13'd0, stored_bytes[i], fin,
                                 fin ? timer_interval : 16'd0, fin));
    end
  endfunction

  function automatic void judge_ack();
    if (awaiting_ack && held_check == ack_sum && held_number == {31'd0, seq_bit}) begin
      owed_q.push_back(make_item(KIND_STOP, 1'b0, 13'd0, 8'd0, 1'b0, 16'd0, 1'b1));
      seq_bit      = ~seq_bit;
      awaiting_ack = 1'b0;
    end
  endfunction

  function automatic void advance_sender(cmd_e cmd, logic [7:0] value, logic fin,
                                         logic [31:0] hdr_seq, logic [31:0] hdr_num,
                                         logic [31:0] hdr_chk);
    case (cmd)
      CMD_MSG: begin
        if (fill_count == 0 && !dropping_msg) begin
          // A message that begins while an ack is awaited is thrown away whole.
          if (awaiting_ack) begin
            dropping_msg = !fin;
            return;
          end
          msg_check = {12'd0, seq_bit};
        end
        if (dropping_msg) begin
          if (fin) dropping_msg = 1'b0;
          return;
        end
        if (fill_count < PAYLOAD_BYTES) begin
          stored_bytes[fill_count] = value;
          msg_check = msg_check + {{5{value[7]}}, value};
          fill_count++;
        end
        if (fin) begin
          // The unused tail of the store goes out as zero bytes.
          while (fill_count < PAYLOAD_BYTES) begin
            stored_bytes[fill_count] = 8'd0;
            fill_count++;
          end
          fill_count   = 0;
          awaiting_ack = 1'b1;
          queue_packet();
        end
      end
      CMD_ACK_HDR: begin
        held_number = hdr_num;
        held_check  = hdr_chk;
        ack_sum     = hdr_seq + hdr_num;
        if (fin) judge_ack();
      end
      CMD_ACK_BYTE: begin
        ack_sum = ack_sum + {{24{value[7]}}, value};
        if (fin) judge_ack();
      end
      CMD_TIMEOUT: begin
        if (awaiting_ack) queue_packet();
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result();
    sender_item_t got;
    sender_item_t want;
    got = make_item(kind_e'(kind_i), seq_number_i, check_value_i, payload_byte_i,
                    start_timer_i, timer_load_i, last_i);
    if (owed_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("[%0t] result with nothing outstanding: kind=%0d seq=%0d chk=%0d pay=%0d",
                 $realtime, got.kind, got.seq, got.check, got.payload);
      return;
    end
    want = owed_q.pop_front();
    if (got.kind !== want.kind || got.seq !== want.seq || got.check !== want.check ||
        got.payload !== want.payload || got.start !== want.start ||
        got.load !== want.load || got.last !== want.last) begin
      failures++;
      if (failures <= 10)
        $display({"[%0t] result mismatch: expected kind=%0d seq=%0d chk=%0d pay=%0d ",
                  "start=%0d load=%0d last=%0d, got kind=%0d seq=%0d chk=%0d pay=%0d ",
                  "start=%0d load=%0d last=%0d"}, $realtime,
                 want.kind, want.seq, want.check, want.payload, want.start, want.load,
                 want.last, got.kind, got.seq, got.check, got.payload, got.start,
                 got.load, got.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q.delete();
      timer_interval = RetransmitReset;
      awaiting_ack   = 1'b0;
      seq_bit        = 1'b0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) stored_bytes[i] = 8'd0;
      fill_count     = 0;
      msg_check      = 13'd0;
      dropping_msg   = 1'b0;
      held_number    = 32'd0;
      held_check     = 32'd0;
      ack_sum        = 32'd0;
      failures       = 0;
      fail_count_o  <= 0;
      owed_count_o  <= 0;
      seq_bit_o     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) timer_interval = cfg_data_i;
      if (pop_i && !empty_i) check_result();
      if (push_i && !full_i)
        advance_sender(cmd_e'(command_i), data_byte_i, last_byte_i, ack_seq_i,
                       ack_number_i, ack_check_i);
      fail_count_o <= failures;
      owed_count_o <= owed_q.size();
      seq_bit_o    <= seq_bit;
    end
  end

endmodule

### verif/alternating_bit_sender_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the alternating-bit sender: clock, reset, stimulus and verdict.
// Depends on abs_pkg, alternating_bit_sender_unit and alternating_bit_sender_checker.
module alternating_bit_sender_unit_tb;
  import abs_pkg::*;

  localparam int PayloadBytes  = 20;
  localparam int LongHold      = 160;
  localparam int WatchdogLimit = 2000;

  typedef enum {FAULT_NONE, FAULT_CHECK, FAULT_NUMBER} ack_fault_e;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               push         = 1'b0;
  logic               full;
  logic [1:0]         command_i    = CMD_MSG;
  logic signed [7:0]  data_byte_i  = '0;
  logic               last_byte_i  = 1'b0;
  logic signed [31:0] ack_seq_i    = '0;
  logic signed [31:0] ack_number_i = '0;
  logic signed [31:0] ack_check_i  = '0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i   = '0;
  logic               empty;
  logic               pop          = 1'b0;
  logic [1:0]         kind_o;
  logic               seq_number_o;
  logic signed [12:0] check_value_o;
  logic signed [7:0]  payload_byte_o;
  logic               start_timer_o;
  logic [15:0]        timer_load_o;
  logic               last_o;

  int   fail_count;
  int   owed_count;
  logic ack_bit;
  logic hold_req    = 1'b0;
  logic steady_tail = 1'b0;
  int   items_sent  = 0;

  always #6 clk_i = ~clk_i;

  alternating_bit_sender_unit #(
    .PAYLOAD_BYTES(PayloadBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .command_i     (command_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .ack_seq_i     (ack_seq_i),
    .ack_number_i  (ack_number_i),
    .ack_check_i   (ack_check_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .seq_number_o  (seq_number_o),
    .check_value_o (check_value_o),
    .payload_byte_o(payload_byte_o),
    .start_timer_o (start_timer_o),
    .timer_load_o  (timer_load_o),
    .last_o        (last_o)
  );

  alternating_bit_sender_checker #(
    .PAYLOAD_BYTES(PayloadBytes)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .command_i     (command_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .ack_seq_i     (ack_seq_i),
    .ack_number_i  (ack_number_i),
    .ack_check_i   (ack_check_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .empty_i       (empty),
    .pop_i         (pop),
    .kind_i        (kind_o),
    .seq_number_i  (seq_number_o),
    .check_value_i (check_value_o),
    .payload_byte_i(payload_byte_o),
    .start_timer_i (start_timer_o),
    .timer_load_i  (timer_load_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .owed_count_o  (owed_count),
    .seq_bit_o     (ack_bit)
  );

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h7F;
      1: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offers one item and returns at the edge where it transfers, with push still high.
  task automatic offer_item(input cmd_e cmd, input logic [7:0] value, input logic fin,
                            input logic [31:0] hdr_seq, input logic [31:0] hdr_num,
                            input logic [31:0] hdr_chk);
    if (!steady_tail && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    command_i    <= cmd;
    data_byte_i  <= value;
    last_byte_i  <= fin;
    ack_seq_i    <= hdr_seq;
    ack_number_i <= hdr_num;
    ack_check_i  <= hdr_chk;
    push         <= 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic offer_message(input int n_bytes);
    for (int i = 0; i < n_bytes; i++)
      offer_item(CMD_MSG, random_byte(), i == n_bytes - 1, $urandom, $urandom, $urandom);
  endtask

  // The ack number comes from the predicted sequence bit; a fault spoils the number or the check on purpose.
  task automatic offer_ack(input ack_fault_e fault, input int n_bytes);
    logic [31:0] hdr_seq;
    logic [31:0] hdr_num;
    logic [31:0] hdr_chk;
    logic [7:0]  body [4];
    int          i;
    hdr_seq = $urandom;
    hdr_num = {31'd0, ack_bit};
    if (fault == FAULT_NUMBER) hdr_num = hdr_num ^ (32'd1 << $urandom_range(0, 31));
    hdr_chk = hdr_seq + hdr_num;
    for (i = 0; i < n_bytes; i++) begin
      body[i] = random_byte();
      hdr_chk = hdr_chk + {{24{body[i][7]}}, body[i]};
    end
    if (fault == FAULT_CHECK) hdr_chk = hdr_chk ^ (32'd1 << $urandom_range(0, 31));
    offer_item(CMD_ACK_HDR, random_byte(), n_bytes == 0, hdr_seq, hdr_num, hdr_chk);
    for (i = 0; i < n_bytes; i++)
      offer_item(CMD_ACK_BYTE, body[i], i == n_bytes - 1, $urandom, $urandom, $urandom);
  endtask

  // Waits until every predicted result has come, then idles so that silent items also finish.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk_i); while (owed_count != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [15:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed exchanges with random content, with some stray items mixed in.
  task automatic exchange_until(input int target);
    int len;
    while (items_sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        offer_item(cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), $urandom,
                   $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 9))
          0: len = $urandom_range(PayloadBytes + 1, PayloadBytes + 4);
          1: len = PayloadBytes;
          2: len = 1;
          default: len = $urandom_range(2, PayloadBytes - 1);
        endcase
        offer_message(len);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2))
            offer_item(CMD_TIMEOUT, 8'($urandom), 1'($urandom), $urandom, $urandom, $urandom);
        if ($urandom_range(0, 4) == 0) offer_message($urandom_range(1, 5));
        if ($urandom_range(0, 3) == 0)
          offer_ack(ack_fault_e'($urandom_range(FAULT_CHECK, FAULT_NUMBER)),
                    $urandom_range(0, 4));
        if ($urandom_range(0, 9) != 0) offer_ack(FAULT_NONE, $urandom_range(0, 4));
      end
    end
  endtask

  // Result side: short random stalls, one long hold-off on request, none in the tail.
  initial begin : result_sink
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req <= 1'b0;
        pop      <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        pop <= 1'b1;
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[alternating_bit_sender_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    int base;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the interval left at its reset value.
    offer_item(CMD_TIMEOUT, 8'h00, 1'b1, 32'd0, 32'd0, 32'd0);
    offer_item(CMD_ACK_HDR, 8'h00, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    offer_item(CMD_ACK_BYTE, 8'hFF, 1'b1, 32'd0, 32'd0, 32'd0);
    offer_item(CMD_MSG, 8'h7F, 1'b0, 32'd0, 32'd0, 32'd0);
    offer_item(CMD_MSG, 8'h80, 1'b1, 32'd0, 32'd0, 32'd0);
    offer_item(CMD_TIMEOUT, 8'h00, 1'b0, 32'd0, 32'd0, 32'd0);
    offer_item(CMD_MSG, 8'h05, 1'b0, 32'd0, 32'd0, 32'd0);
    offer_item(CMD_MSG, 8'h06, 1'b1, 32'd0, 32'd0, 32'd0);
    offer_item(CMD_MSG, 8'h07, 1'b1, 32'd0, 32'd0, 32'd0);
    offer_ack(FAULT_CHECK, 0);
    offer_ack(FAULT_NUMBER, 1);
    offer_ack(FAULT_NONE, 2);
    offer_item(CMD_MSG, 8'h80, 1'b1, 32'd0, 32'd0, 32'd0);
    offer_ack(FAULT_NONE, 0);
    repeat (4) offer_item(CMD_MSG, 8'h80, items_sent % 4 == 3, 32'd0, 32'd0, 32'd0);
    offer_ack(FAULT_NONE, 1);
    base = items_sent;

    settle();
    write_interval(16'hFFFF);
    exchange_until(base + 55);

    settle();
    write_interval(16'd1);
    hold_req <= 1'b1;
    exchange_until(base + 105);

    settle();
    write_interval(16'($urandom_range(2, 65534)));
    exchange_until(base + 155);

    settle();
    write_interval(16'h8000);
    steady_tail <= 1'b1;
    exchange_until(base + 195);

    push <= 1'b0;
    do @(posedge clk_i); while (owed_count != 0);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && owed_count == 0)
      $display("[alternating_bit_sender_unit] OK");
    else
      $display("[alternating_bit_sender_unit] ERROR");
    $finish;
  end

endmodule
